// ----- src/dft_pkg.sv -----
package dft_pkg;

  // Register stages from the input handshake to the output register.
  localparam int unsigned PIPE_DEPTH = 7;

  // Decision made ahead of the wide product compare.
  typedef struct packed {
    logic decided;  // keep is final, skip the product compare
    logic keep;     // early answer, valid when decided
  } dft_ctrl_t;

endpackage

// ----- src/delaunay_flip_test.sv -----
// Delaunay edge-flip test: keep or flip the shared edge of one quadrilateral per item.
// Result path: keep_edge_o is registered at the end of the stage chain:
//   diff, products, sums, classify, wide partial products, product join, compare.
// Throughput: 1 item per cycle if unstalled; each stage has its own valid bit, so
//   bubbles collapse; input stalls only with all 7 stages full behind a held result.
// Reset: rst_ni async active low clears all stage valid bits; payload is not reset.
module delaunay_flip_test #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] new_px_i,
  input  logic signed [COORD_BITS-1:0] new_py_i,
  input  logic signed [COORD_BITS-1:0] edge_ax_i,
  input  logic signed [COORD_BITS-1:0] edge_ay_i,
  input  logic signed [COORD_BITS-1:0] edge_bx_i,
  input  logic signed [COORD_BITS-1:0] edge_by_i,
  input  logic signed [COORD_BITS-1:0] opp_x_i,
  input  logic signed [COORD_BITS-1:0] opp_y_i,
  input  logic                         opp_is_new_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         keep_edge_o
);
  import dft_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * COORD_BITS + 3;

  // stage 1: coordinate differences
  logic                 s1_vld, s1_rdy;
  logic signed [DW-1:0] s1_dx [7];
  logic signed [DW-1:0] s1_dy [7];
  logic                 s1_opp;

  // stages 2-3: products, then cross and dot sums
  logic                 s3_vld, s3_rdy;
  logic                 s3_opp, s3_c1_neg, s3_c2_pos;
  logic signed [SW-1:0] s3_sa, s3_sb, s3_sc, s3_sd;

  // stage 4: early decision and compare operands
  logic                 s4_vld, s4_rdy;
  dft_ctrl_t            s4_ctrl;
  logic [SW-1:0]        s4_a, s4_b, s4_c, s4_d;

  // stages 5-7: wide product compare into the output register
  logic                 s5_rdy;
  logic                 out_rdy;

  assign out_rdy    = !out_stall_i;
  assign in_stall_o = !s1_rdy;

  dft_diff #(
    .COORD_BITS(COORD_BITS)
  ) u_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_valid_i),
    .rdy_o  (s1_rdy),
    .px_i   (new_px_i),
    .py_i   (new_py_i),
    .lx_i   (edge_ax_i),
    .ly_i   (edge_ay_i),
    .rx_i   (edge_bx_i),
    .ry_i   (edge_by_i),
    .qx_i   (opp_x_i),
    .qy_i   (opp_y_i),
    .opp_i  (opp_is_new_i),
    .vld_o  (s1_vld),
    .rdy_i  (s3_rdy),
    .dx_o   (s1_dx),
    .dy_o   (s1_dy),
    .opp_o  (s1_opp)
  );

  dft_prod #(
    .COORD_BITS(COORD_BITS)
  ) u_prod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (s1_vld),
    .rdy_o    (s3_rdy),
    .dx_i     (s1_dx),
    .dy_i     (s1_dy),
    .opp_i    (s1_opp),
    .vld_o    (s3_vld),
    .rdy_i    (s4_rdy),
    .opp_o    (s3_opp),
    .c1_neg_o (s3_c1_neg),
    .c2_pos_o (s3_c2_pos),
    .sa_o     (s3_sa),
    .sb_o     (s3_sb),
    .sc_o     (s3_sc),
    .sd_o     (s3_sd)
  );

  dft_classify #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (s3_vld),
    .rdy_o    (s4_rdy),
    .opp_i    (s3_opp),
    .c1_neg_i (s3_c1_neg),
    .c2_pos_i (s3_c2_pos),
    .sa_i     (s3_sa),
    .sb_i     (s3_sb),
    .sc_i     (s3_sc),
    .sd_i     (s3_sd),
    .vld_o    (s4_vld),
    .rdy_i    (s5_rdy),
    .ctrl_o   (s4_ctrl),
    .a_o      (s4_a),
    .b_o      (s4_b),
    .c_o      (s4_c),
    .d_o      (s4_d)
  );

  dft_wide_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_wide_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s4_vld),
    .rdy_o  (s5_rdy),
    .ctrl_i (s4_ctrl),
    .a_i    (s4_a),
    .b_i    (s4_b),
    .c_i    (s4_c),
    .d_i    (s4_d),
    .vld_o  (out_valid_o),
    .rdy_i  (out_rdy),
    .keep_o (keep_edge_o)
  );

endmodule

// ----- src/dft_diff.sv -----
module dft_diff #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  output logic                         rdy_o,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] lx_i,
  input  logic signed [COORD_BITS-1:0] ly_i,
  input  logic signed [COORD_BITS-1:0] rx_i,
  input  logic signed [COORD_BITS-1:0] ry_i,
  input  logic signed [COORD_BITS-1:0] qx_i,
  input  logic signed [COORD_BITS-1:0] qy_i,
  input  logic                         opp_i,
  output logic                         vld_o,
  input  logic                         rdy_i,
  // index: 0 L-P, 1 Q-P, 2 R-P, 3 P-R, 4 P-L, 5 Q-R, 6 Q-L
  output logic signed [COORD_BITS:0]   dx_o [7],
  output logic signed [COORD_BITS:0]   dy_o [7],
  output logic                         opp_o
);
  import dft_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic                 vld_q;
  logic                 en;
  logic signed [DW-1:0] dx_d [7];
  logic signed [DW-1:0] dy_d [7];
  logic signed [DW-1:0] dx_q [7];
  logic signed [DW-1:0] dy_q [7];
  logic                 opp_q;

  function automatic logic signed [DW-1:0] sub(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
    sub = DW'(a) - DW'(b);
  endfunction

  assign en    = !vld_q || rdy_i;
  assign rdy_o = en;

  always_comb begin
    dx_d[0] = sub(lx_i, px_i);  dy_d[0] = sub(ly_i, py_i);
    dx_d[1] = sub(qx_i, px_i);  dy_d[1] = sub(qy_i, py_i);
    dx_d[2] = sub(rx_i, px_i);  dy_d[2] = sub(ry_i, py_i);
    dx_d[3] = sub(px_i, rx_i);  dy_d[3] = sub(py_i, ry_i);
    dx_d[4] = sub(px_i, lx_i);  dy_d[4] = sub(py_i, ly_i);
    dx_d[5] = sub(qx_i, rx_i);  dy_d[5] = sub(qy_i, ry_i);
    dx_d[6] = sub(qx_i, lx_i);  dy_d[6] = sub(qy_i, ly_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      opp_q <= opp_i;
    end
  end

  assign vld_o = vld_q;
  assign dx_o  = dx_q;
  assign dy_o  = dy_q;
  assign opp_o = opp_q;

endmodule

// ----- src/dft_prod.sv -----
module dft_prod #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  logic signed [COORD_BITS:0]    dx_i [7],
  input  logic signed [COORD_BITS:0]    dy_i [7],
  input  logic                          opp_i,
  output logic                          vld_o,
  input  logic                          rdy_i,
  output logic                          opp_o,
  output logic                          c1_neg_o,
  output logic                          c2_pos_o,
  output logic signed [2*COORD_BITS+2:0] sa_o,
  output logic signed [2*COORD_BITS+2:0] sb_o,
  output logic signed [2*COORD_BITS+2:0] sc_o,
  output logic signed [2*COORD_BITS+2:0] sd_o
);
  import dft_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic                 vld_a_q, vld_b_q;
  logic                 en_a, en_b;
  logic signed [DW-1:0] ma [12];
  logic signed [DW-1:0] mb [12];
  logic signed [PW-1:0] prod_d [12];
  logic signed [PW-1:0] prod_q [12];
  logic                 opp_a_q, opp_b_q;
  logic signed [SW-1:0] c1, c2, sa_d, sb_d, sc_d, sd_d;
  logic signed [SW-1:0] sa_q, sb_q, sc_q, sd_q;
  logic                 c1_neg_q, c2_pos_q;

  assign en_b  = !vld_b_q || rdy_i;
  assign en_a  = !vld_a_q || en_b;
  assign rdy_o = en_a;

  // operand pairs, two per cross or dot product
  always_comb begin
    ma[0]  = dx_i[0]; mb[0]  = dy_i[1];
    ma[1]  = dy_i[0]; mb[1]  = dx_i[1];
    ma[2]  = dx_i[2]; mb[2]  = dy_i[1];
    ma[3]  = dy_i[2]; mb[3]  = dx_i[1];
    ma[4]  = dx_i[3]; mb[4]  = dx_i[4];
    ma[5]  = dy_i[3]; mb[5]  = dy_i[4];
    ma[6]  = dx_i[5]; mb[6]  = dx_i[6];
    ma[7]  = dy_i[5]; mb[7]  = dy_i[6];
    ma[8]  = dx_i[3]; mb[8]  = dy_i[4];
    ma[9]  = dy_i[3]; mb[9]  = dx_i[4];
    ma[10] = dx_i[5]; mb[10] = dy_i[6];
    ma[11] = dy_i[5]; mb[11] = dx_i[6];
  end

  for (genvar g = 0; g < 12; g++) begin : g_mul
    assign prod_d[g] = PW'(ma[g]) * PW'(mb[g]);
  end

  always_comb begin
    c1   = SW'(prod_q[0])  - SW'(prod_q[1]);
    c2   = SW'(prod_q[2])  - SW'(prod_q[3]);
    sa_d = SW'(prod_q[4])  + SW'(prod_q[5]);
    sb_d = SW'(prod_q[6])  + SW'(prod_q[7]);
    sc_d = SW'(prod_q[8])  - SW'(prod_q[9]);
    sd_d = SW'(prod_q[10]) - SW'(prod_q[11]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (en_a) begin
        vld_a_q <= vld_i;
      end
      if (en_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      prod_q  <= prod_d;
      opp_a_q <= opp_i;
    end
    if (en_b) begin
      opp_b_q  <= opp_a_q;
      c1_neg_q <= c1[SW-1];
      c2_pos_q <= !c2[SW-1] && (c2 != '0);
      sa_q     <= sa_d;
      sb_q     <= sb_d;
      sc_q     <= sc_d;
      sd_q     <= sd_d;
    end
  end

  assign vld_o    = vld_b_q;
  assign opp_o    = opp_b_q;
  assign c1_neg_o = c1_neg_q;
  assign c2_pos_o = c2_pos_q;
  assign sa_o     = sa_q;
  assign sb_o     = sb_q;
  assign sc_o     = sc_q;
  assign sd_o     = sd_q;

endmodule

// ----- src/dft_classify.sv -----
module dft_classify #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  output logic                           rdy_o,
  input  logic                           opp_i,
  input  logic                           c1_neg_i,
  input  logic                           c2_pos_i,
  input  logic signed [2*COORD_BITS+2:0] sa_i,
  input  logic signed [2*COORD_BITS+2:0] sb_i,
  input  logic signed [2*COORD_BITS+2:0] sc_i,
  input  logic signed [2*COORD_BITS+2:0] sd_i,
  output logic                           vld_o,
  input  logic                           rdy_i,
  output dft_pkg::dft_ctrl_t             ctrl_o,
  // keep exactly when a*b >= c*d
  output logic        [2*COORD_BITS+2:0] a_o,
  output logic        [2*COORD_BITS+2:0] b_o,
  output logic        [2*COORD_BITS+2:0] c_o,
  output logic        [2*COORD_BITS+2:0] d_o
);
  import dft_pkg::*;

  localparam int unsigned MW = 2 * COORD_BITS + 3;

  logic            vld_q, en;
  logic            sa_neg, sb_neg;
  dft_ctrl_t       ctrl_d, ctrl_q;
  logic [MW-1:0]   a_d, b_d, c_d, d_d;
  logic [MW-1:0]   a_q, b_q, c_q, d_q;
  logic [MW-1:0]   ma, mb, mc, md;

  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
    mag = v[MW-1] ? (~v + MW'(1)) : v;
  endfunction

  assign en    = !vld_q || rdy_i;
  assign rdy_o = en;

  assign sa_neg = sa_i[MW-1];
  assign sb_neg = sb_i[MW-1];
  assign ma     = mag(sa_i);
  assign mb     = mag(sb_i);
  assign mc     = mag(sc_i);
  assign md     = mag(sd_i);

  always_comb begin
    ctrl_d.decided = 1'b1;
    ctrl_d.keep    = 1'b1;
    if (opp_i || c1_neg_i || c2_pos_i || (!sa_neg && !sb_neg)) begin
      ctrl_d.keep = 1'b1;
    end else if (sa_neg && sb_neg) begin
      ctrl_d.keep = 1'b0;
    end else begin
      ctrl_d.decided = 1'b0;
    end
    // mixed signs: keep when Sc*Sb + Sa*Sd >= 0
    if (sa_neg) begin
      a_d = mc; b_d = mb; c_d = ma; d_d = md;
    end else begin
      a_d = ma; b_d = md; c_d = mb; d_d = mc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctrl_q <= ctrl_d;
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      d_q    <= d_d;
    end
  end

  assign vld_o  = vld_q;
  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign c_o    = c_q;
  assign d_o    = d_q;

endmodule

// ----- src/dft_wide_cmp.sv -----
module dft_wide_cmp #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  output logic                    rdy_o,
  input  dft_pkg::dft_ctrl_t      ctrl_i,
  input  logic [2*COORD_BITS+2:0] a_i,
  input  logic [2*COORD_BITS+2:0] b_i,
  input  logic [2*COORD_BITS+2:0] c_i,
  input  logic [2*COORD_BITS+2:0] d_i,
  output logic                    vld_o,
  input  logic                    rdy_i,
  output logic                    keep_o
);
  import dft_pkg::*;

  localparam int unsigned MW  = 2 * COORD_BITS + 3;
  localparam int unsigned H   = (MW + 1) / 2;   // low half width
  localparam int unsigned PPW = 2 * H;
  localparam int unsigned FW  = 2 * MW;

  logic            vld_p_q, vld_s_q, vld_o_q;
  logic            en_p, en_s, en_o;
  dft_ctrl_t       ctrl_p_q, ctrl_s_q;
  // partial products: 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
  logic [PPW-1:0]  ab_pp_d [4];
  logic [PPW-1:0]  cd_pp_d [4];
  logic [PPW-1:0]  ab_pp_q [4];
  logic [PPW-1:0]  cd_pp_q [4];
  logic [FW-1:0]   ab_d, cd_d, ab_q, cd_q;
  logic            keep_q;

  function automatic logic [PPW-1:0] lo(input logic [MW-1:0] v);
    lo = PPW'(v[H-1:0]);
  endfunction

  function automatic logic [PPW-1:0] hi(input logic [MW-1:0] v);
    hi = PPW'(v[MW-1:H]);
  endfunction

  function automatic logic [FW-1:0] join_pp(input logic [PPW-1:0] pp0,
                                            input logic [PPW-1:0] pp1,
                                            input logic [PPW-1:0] pp2,
                                            input logic [PPW-1:0] pp3);
    join_pp = (FW'(pp3) << (2 * H)) + ((FW'(pp1) + FW'(pp2)) << H) + FW'(pp0);
  endfunction

  assign en_o  = !vld_o_q || rdy_i;
  assign en_s  = !vld_s_q || en_o;
  assign en_p  = !vld_p_q || en_s;
  assign rdy_o = en_p;

  always_comb begin
    ab_pp_d[0] = lo(a_i) * lo(b_i);
    ab_pp_d[1] = lo(a_i) * hi(b_i);
    ab_pp_d[2] = hi(a_i) * lo(b_i);
    ab_pp_d[3] = hi(a_i) * hi(b_i);
    cd_pp_d[0] = lo(c_i) * lo(d_i);
    cd_pp_d[1] = lo(c_i) * hi(d_i);
    cd_pp_d[2] = hi(c_i) * lo(d_i);
    cd_pp_d[3] = hi(c_i) * hi(d_i);
  end

  assign ab_d = join_pp(ab_pp_q[0], ab_pp_q[1], ab_pp_q[2], ab_pp_q[3]);
  assign cd_d = join_pp(cd_pp_q[0], cd_pp_q[1], cd_pp_q[2], cd_pp_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
      vld_s_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else begin
      if (en_p) begin
        vld_p_q <= vld_i;
      end
      if (en_s) begin
        vld_s_q <= vld_p_q;
      end
      if (en_o) begin
        vld_o_q <= vld_s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p) begin
      ctrl_p_q <= ctrl_i;
      ab_pp_q  <= ab_pp_d;
      cd_pp_q  <= cd_pp_d;
    end
    if (en_s) begin
      ctrl_s_q <= ctrl_p_q;
      ab_q     <= ab_d;
      cd_q     <= cd_d;
    end
    if (en_o) begin
      keep_q <= ctrl_s_q.decided ? ctrl_s_q.keep : (ab_q >= cd_q);
    end
  end

  assign vld_o  = vld_o_q;
  assign keep_o = keep_q;

endmodule

// ----- src/dft_checker.sv -----
module dft_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic keep_edge_o
);
  import dft_pkg::*;

  logic       in_acc, out_acc;
  logic [3:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(keep_edge_o))
    else $error("result changed while stalled");

  // input only backs up when every stage is full and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // never more items in flight than stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 4'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // no result without an item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == '0 |-> !out_valid_o)
    else $error("result shown with no item in flight");

endmodule

bind delaunay_flip_test dft_checker u_dft_checker (.*);
